/* sv/cse_pkg.sv */
// cse_pkg: shared constants and types for the cosine similarity engine.
// No dependencies.
`default_nettype none
package cse_pkg;
	localparam int MAX_LEN_DEF = 4096;
	localparam int ACC_W = 48;
	localparam int PROD_W = 96;
	localparam int SQ_W = 61;
	localparam int ONE_Q14 = 16384;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_MUL,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic acc_en;
		logic clr;
		logic mul_step;
		logic sqrt_start;
		logic sqrt_step;
		logic div_start;
		logic div_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic div_done;
		logic zero;
	} sts_t;
endpackage
`default_nettype wire

/* sv/cse_datapath.sv */
// cse_datapath: saturating accumulators, multi-cycle product, square root and divider.
// Depends on cse_pkg.
`default_nettype none
module cse_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cse_pkg::cmd_t       cmd,
	output cse_pkg::sts_t            sts,
	input  wire logic signed [15:0]  elem_a,
	input  wire logic signed [15:0]  elem_b,
	output logic signed [15:0]       sim_q,
	output logic                     zn_q
);
	localparam int AW = cse_pkg::ACC_W;
	localparam logic signed [AW:0] AMAX = {2'b00, {(AW-1){1'b1}}};
	localparam logic signed [AW:0] AMIN = {2'b11, {(AW-1){1'b0}}};

	logic signed [AW-1:0] dot_q, na_q, nb_q;
	logic signed [31:0] pab, paa, pbb;

	function automatic logic signed [AW-1:0] sat(input logic signed [AW-1:0] acc,
		input logic signed [31:0] inc);
		logic signed [AW:0] s;
		s = {acc[AW-1], acc} + (AW+1)'(inc);
		if (s > AMAX) return AMAX[AW-1:0];
		if (s < AMIN) return AMIN[AW-1:0];
		return s[AW-1:0];
	endfunction

	assign pab = elem_a * elem_b;
	assign paa = elem_a * elem_a;
	assign pbb = elem_b * elem_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
		end else if (cmd.clr) begin
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
		end else if (cmd.acc_en) begin
			dot_q <= sat(dot_q, pab);
			na_q <= sat(na_q, paa);
			nb_q <= sat(nb_q, pbb);
		end
	end

	// product: 48x48 as 24-bit digits of nb, one per cycle
	logic [95:0] p_q;
	logic [0:0] mc_q;
	logic [47:0] mul_row;
	assign mul_row = mc_q[0] ? {24'd0, nb_q[47:24]} : {24'd0, nb_q[23:0]};
	logic [71:0] pp;
	assign pp = na_q[46:0] * mul_row[23:0];
	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			if (!mc_q[0]) p_q <= {24'd0, pp};
			else p_q <= p_q + {pp, 24'd0};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mc_q <= 1'b0;
		else if (cmd.mul_step) mc_q <= ~mc_q;
		else if (cmd.clr) mc_q <= 1'b0;
	end
	assign sts.mul_done = mc_q[0];
	assign sts.zero = (na_q <= 0) || (nb_q <= 0);

	// restoring square root of P*2^28, two bits of radicand per cycle
	logic [121:0] x_q;
	logic [62:0] rem_q;
	logic [60:0] r_q;
	logic [5:0] sc_q;
	logic [62:0] trial;
	logic [62:0] rem_sh;
	assign rem_sh = {rem_q[60:0], x_q[121:120]};
	assign trial = {r_q, 2'b01};
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			x_q <= {p_q[93:0], 28'd0};
			rem_q <= '0;
			r_q <= '0;
			sc_q <= 6'd60;
		end else if (cmd.sqrt_step) begin
			x_q <= {x_q[119:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				r_q <= {r_q[59:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				r_q <= {r_q[59:0], 1'b0};
			end
			sc_q <= sc_q - 6'd1;
		end
	end
	assign sts.sqrt_done = (sc_q == 6'd0) && !cmd.sqrt_start;

	// restoring divide: |dot| * 2^29 / S, 77 quotient bits
	logic [47:0] mag;
	assign mag = dot_q[AW-1] ? 48'(-dot_q) : 48'(dot_q);
	logic [76:0] dn_q, q_q;
	logic [61:0] dr_q;
	logic [6:0] dc_q;
	logic [61:0] dsh;
	assign dsh = {dr_q[60:0], dn_q[76]};
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dn_q <= {mag, 29'd0};
			dr_q <= '0;
			q_q <= '0;
			dc_q <= 7'd77;
		end else if (cmd.div_step) begin
			dn_q <= {dn_q[75:0], 1'b0};
			if (dsh >= {1'b0, r_q}) begin
				dr_q <= dsh - {1'b0, r_q};
				q_q <= {q_q[75:0], 1'b1};
			end else begin
				dr_q <= dsh;
				q_q <= {q_q[75:0], 1'b0};
			end
			dc_q <= dc_q - 7'd1;
		end
	end
	assign sts.div_done = (dc_q == 7'd0) && !cmd.div_start;

	logic [76:0] rnd;
	logic [15:0] m16;
	assign rnd = (q_q + 77'd1) >> 1;
	assign m16 = (rnd > 77'(cse_pkg::ONE_Q14)) ? 16'(cse_pkg::ONE_Q14) : rnd[15:0];
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			zn_q <= sts.zero;
			if (sts.zero) sim_q <= '0;
			else sim_q <= dot_q[AW-1] ? -$signed(m16) : $signed(m16);
		end
	end
endmodule
`default_nettype wire

/* sv/cse_ctrl.sv */
// cse_ctrl: sequencer for accumulate, product, root, divide and output.
// Depends on cse_pkg.
`default_nettype none
module cse_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           last,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire cse_pkg::sts_t  sts,
	output cse_pkg::cmd_t       cmd
);
	cse_pkg::state_t st_q, st_d;
	logic fire;
	assign fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= cse_pkg::ST_ACC;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			cse_pkg::ST_ACC: if (fire && last) st_d = cse_pkg::ST_MUL;
			cse_pkg::ST_MUL: if (sts.mul_done) st_d = cse_pkg::ST_SQRT;
			cse_pkg::ST_SQRT: if (sts.sqrt_done) st_d = cse_pkg::ST_DIV;
			cse_pkg::ST_DIV: if (sts.div_done) st_d = cse_pkg::ST_OUT;
			cse_pkg::ST_OUT: if (out_ready) st_d = cse_pkg::ST_ACC;
			default: st_d = cse_pkg::ST_ACC;
		endcase
	end

	logic first_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else first_q <= (st_d != st_q);
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (st_q)
			cse_pkg::ST_ACC: begin
				in_ready = 1'b1;
				cmd.acc_en = fire;
			end
			cse_pkg::ST_MUL: cmd.mul_step = 1'b1;
			cse_pkg::ST_SQRT: begin
				cmd.sqrt_start = first_q;
				cmd.sqrt_step = !first_q;
			end
			cse_pkg::ST_DIV: begin
				cmd.div_start = first_q;
				cmd.div_step = !first_q;
				cmd.fin = sts.div_done;
			end
			cse_pkg::ST_OUT: begin
				out_valid = 1'b1;
				cmd.clr = out_ready;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* sv/cosine_similarity_engine.sv */
// cosine_similarity_engine: top level, ties controller to datapath.
// Depends on cse_pkg, cse_ctrl, cse_datapath.
//
// Element pairs (elem_a, elem_b, last) arrive on a valid/ready channel, one
// transfer per cycle while accumulating. The transfer with last set closes the
// vector; the input then stalls while the result is computed: the norm product,
// the square root (one result bit per cycle) and the divide (one quotient bit
// per cycle). The result (similarity, zero_norm) then waits on the output
// channel until taken; the accumulators clear on that transfer and input
// reopens next cycle. Reset clears the accumulators and returns to
// accumulating. MAX_LEN bounds nothing in hardware: accumulators saturate.
`default_nettype none
module cosine_similarity_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] elem_a,
	input  wire logic signed [15:0] elem_b,
	input  wire logic               last,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      similarity,
	output logic                    zero_norm
);
	cse_pkg::cmd_t cmd;
	cse_pkg::sts_t sts;

	cse_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .last,
		.out_valid, .out_ready, .sts, .cmd
	);

	cse_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .elem_a, .elem_b,
		.sim_q(similarity), .zn_q(zero_norm)
	);
endmodule
`default_nettype wire

/* tb/cosine_similarity_engine_tb.sv */
// Testbench for cosine_similarity_engine: streams vector pairs over valid/ready
// and checks each similarity result against a bit-accurate predictor.
// Depends on cse_pkg and the cosine_similarity_engine RTL.
`timescale 1ns / 100ps
`default_nettype none
module cosine_similarity_engine_tb;
	localparam longint SAT_HI = 64'sd140737488355327;
	localparam longint SAT_LO = -64'sd140737488355328;

	localparam int VEC_RAND = 0;
	localparam int VEC_SAME = 1;
	localparam int VEC_NEG = 2;
	localparam int VEC_SMALL = 3;
	localparam int VEC_NEAR = 4;

	typedef struct {
		logic signed [15:0] sim;
		logic               zn;
	} cos_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] elem_a = '0;
	logic signed [15:0] elem_b = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] similarity;
	logic zero_norm;

	longint dot_sum, norm_a_sum, norm_b_sum;
	cos_result_t pending_cos[$];
	int errors = 0;
	int hold_off = 0;
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;

	cosine_similarity_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.elem_a(elem_a), .elem_b(elem_b), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.similarity(similarity), .zero_norm(zero_norm)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint sat48(longint x);
		if (x > SAT_HI) return SAT_HI;
		if (x < SAT_LO) return SAT_LO;
		return x;
	endfunction

	function automatic logic signed [15:0] cos_q14(longint d, longint na, longint nb);
		logic [127:0] p, t;
		logic [63:0] s, mag, q;
		logic [127:0] m;
		p = (128'(na) * 128'(nb)) << 28;
		s = '0;
		for (int b = 60; b >= 0; b--) begin
			t = 128'(s | (64'd1 << b));
			if (t * t <= p) s = s | (64'd1 << b);
		end
		if (s == 0) return '0;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		q = mag / s;
		if (q >= 2) begin
			mag = cse_pkg::ONE_Q14;
		end else begin
			m = (128'(mag) << 29) / 128'(s);
			mag = 64'((m + 1) >> 1);
			if (mag > cse_pkg::ONE_Q14) mag = cse_pkg::ONE_Q14;
		end
		return (d < 0) ? -16'(mag) : 16'(mag);
	endfunction

	task automatic predict_pair(logic signed [15:0] a, logic signed [15:0] b, logic l);
		cos_result_t r;
		dot_sum = sat48(dot_sum + longint'(a) * longint'(b));
		norm_a_sum = sat48(norm_a_sum + longint'(a) * longint'(a));
		norm_b_sum = sat48(norm_b_sum + longint'(b) * longint'(b));
		if (l) begin
			if (norm_a_sum <= 0 || norm_b_sum <= 0) begin
				r.sim = '0;
				r.zn = 1'b1;
			end else begin
				r.sim = cos_q14(dot_sum, norm_a_sum, norm_b_sum);
				r.zn = 1'b0;
			end
			pending_cos = {pending_cos, r};
			dot_sum = 0;
			norm_a_sum = 0;
			norm_b_sum = 0;
		end
	endtask

	task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic l);
		while (send_gaps && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		elem_a <= a;
		elem_b <= b;
		last <= l;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pair(a, b, l);
		@(negedge clk);
	endtask

	task automatic send_vector(int len, int mode);
		logic signed [15:0] a, b;
		for (int i = 0; i < len; i++) begin
			a = 16'($urandom);
			b = 16'($urandom);
			case (mode)
				VEC_SAME: b = a;
				VEC_NEG: b = -a;
				VEC_SMALL: begin
					a = 16'($urandom_range(511)) - 16'sd256;
					b = 16'($urandom_range(511)) - 16'sd256;
				end
				VEC_NEAR: b = a + 16'($urandom_range(64)) - 16'sd32;
				default: ;
			endcase
			send_pair(a, b, i == len - 1);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_cos.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	always @(posedge clk) begin
		cos_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cos.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer: sim=%0d zn=%0b",
					similarity, zero_norm);
			end else begin
				e = pending_cos.pop_front();
				if (similarity !== e.sim || zero_norm !== e.zn) begin
					errors++;
					if (errors <= 10) $display("mismatch: exp sim=%0d zn=%0b got sim=%0d zn=%0b",
						e.sim, e.zn, similarity, zero_norm);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			out_ready <= !(recv_gaps && $urandom_range(99) < 14);
		end
	end

	task automatic test_directed();
		send_pair(16'sh7fff, 16'sh7fff, 1'b1);
		send_pair(-16'sh8000, -16'sh8000, 1'b1);
		send_pair(-16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sd256, -16'sd256, 1'b1);
		send_pair(16'sd0, 16'sd5, 1'b1);
		send_pair(16'sd5, 16'sd0, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd1, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd1, 1'b1);
		send_pair(16'sd3, 16'sd4, 1'b0);
		send_pair(-16'sd4, 16'sd3, 1'b1);
		send_pair(16'sd1, 16'sd1, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);
		send_pair(16'shffff, 16'sh5555, 1'b0);
		send_pair(16'shaaaa, 16'sh0001, 1'b1);
	endtask

	// long vector of full-scale pairs, sums grow far past 32 bits
	task automatic test_full_scale();
		for (int i = 0; i < 100; i++)
			send_pair(-16'sh8000, (i % 3 == 0) ? 16'sh7fff : -16'sh8000, i == 99);
	endtask

	task automatic test_random(int budget);
		int len;
		while (budget > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(200, 64) : $urandom_range(16, 1);
			send_vector(len, $urandom_range(4));
			budget -= len;
		end
	endtask

	task automatic test_backpressure();
		hold_off = 600;
		for (int i = 0; i < 6; i++) send_vector(3, VEC_RAND);
		drain_results();
		recv_gaps = 1'b0;
		send_gaps = 1'b0;
		for (int i = 0; i < 20; i++) send_vector($urandom_range(12, 1), VEC_SMALL);
		recv_gaps = 1'b1;
		send_gaps = 1'b1;
		drain_results();
	endtask

	initial begin
		dot_sum = 0;
		norm_a_sum = 0;
		norm_b_sum = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_backpressure();
		test_random(1700);
		test_full_scale();
		drain_results();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
